@@ rtl/core/dxt_texture_block_decoder_core_macros.svh @@
// assertion macros for the texture block decoder
`ifndef DXT_TEXTURE_BLOCK_DECODER_CORE_MACROS_SVH
`define DXT_TEXTURE_BLOCK_DECODER_CORE_MACROS_SVH

// check on every clock edge outside reset
`define DXTD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check on every clock edge, reset included
`define DXTD_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/dxtd_pkg.sv @@
// types, tables and divide helpers shared by the texture block decoder
package dxtd_pkg;

	localparam int unsigned Texels = 16;
	localparam int unsigned Max5 = 31;
	localparam int unsigned Max6 = 63;

	// reciprocal constants: floor(x / d) == (x * recip) >> shift over the used range
	localparam int unsigned Recip3 = 683;
	localparam int unsigned Shift3 = 11;
	localparam int unsigned Recip5 = 1639;
	localparam int unsigned Shift5 = 13;
	localparam int unsigned Recip7 = 2341;
	localparam int unsigned Shift7 = 14;

	typedef struct packed {
		logic [63:0] color_half;
		logic [63:0] alpha_half;
	} block_t;

	typedef struct packed {
		logic [3:0] texel_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       last_texel;
	} texel_t;

	// endpoint expansions and weighted sums, before the divides
	typedef struct packed {
		logic [2:0][7:0]  e0;
		logic [2:0][7:0]  e1;
		logic [2:0][9:0]  sum_a;
		logic [2:0][9:0]  sum_b;
		logic [2:0][8:0]  sum_m;
		logic             four_color;
		logic [7:0]       a0;
		logic [7:0]       a1;
		logic [5:0][10:0] sum7;
		logic [3:0][10:0] sum5;
		logic             seven_step;
		logic [31:0]      cidx;
		logic [47:0]      aidx;
	} wsum_t;

	typedef struct packed {
		logic [3:0][2:0][7:0] pal;
		logic [7:0][7:0]      ramp;
		logic [31:0]          cidx;
		logic [47:0]          aidx;
	} palette_t;

	typedef logic [7:0] exp5_tab_t [32];
	typedef logic [7:0] exp6_tab_t [64];

	function automatic exp5_tab_t build_exp5();
		exp5_tab_t t;
		for (int i = 0; i < 32; i++) begin
			t[i] = 8'((i * 255) / Max5);
		end
		return t;
	endfunction

	function automatic exp6_tab_t build_exp6();
		exp6_tab_t t;
		for (int i = 0; i < 64; i++) begin
			t[i] = 8'((i * 255) / Max6);
		end
		return t;
	endfunction

	localparam exp5_tab_t Exp5Tab = build_exp5();
	localparam exp6_tab_t Exp6Tab = build_exp6();

	function automatic logic [7:0] div3(logic [9:0] x);
		logic [20:0] p;
		p = 21'(x) * 21'(Recip3);
		return 8'(p >> Shift3);
	endfunction

	function automatic logic [7:0] div5(logic [10:0] x);
		logic [21:0] p;
		p = 22'(x) * 22'(Recip5);
		return 8'(p >> Shift5);
	endfunction

	function automatic logic [7:0] div7(logic [10:0] x);
		logic [22:0] p;
		p = 23'(x) * 23'(Recip7);
		return 8'(p >> Shift7);
	endfunction

endpackage

@@ rtl/core/dxtd_weights.sv @@
// endpoint expansion and weighted sums for colour palette and alpha ramp
module dxtd_weights (
	input  dxtd_pkg::block_t blk,
	output dxtd_pkg::wsum_t  w
);
	import dxtd_pkg::*;

	logic [15:0] c0;
	logic [15:0] c1;
	logic [7:0]  a0;
	logic [7:0]  a1;

	assign c0 = blk.color_half[15:0];
	assign c1 = blk.color_half[31:16];
	assign a0 = blk.alpha_half[7:0];
	assign a1 = blk.alpha_half[15:8];

	always_comb begin
		w = '0;
		w.e0[0] = Exp5Tab[c0[15:11]];
		w.e0[1] = Exp6Tab[c0[10:5]];
		w.e0[2] = Exp5Tab[c0[4:0]];
		w.e1[0] = Exp5Tab[c1[15:11]];
		w.e1[1] = Exp6Tab[c1[10:5]];
		w.e1[2] = Exp5Tab[c1[4:0]];
		for (int k = 0; k < 3; k++) begin
			w.sum_a[k] = {1'b0, w.e0[k], 1'b0} + 10'(w.e1[k]);
			w.sum_b[k] = 10'(w.e0[k]) + {1'b0, w.e1[k], 1'b0};
			w.sum_m[k] = 9'(w.e0[k]) + 9'(w.e1[k]);
		end
		w.four_color = c0 > c1;
		w.a0 = a0;
		w.a1 = a1;
		for (int i = 1; i < 7; i++) begin
			w.sum7[i - 1] = 11'(a0) * 11'(7 - i) + 11'(a1) * 11'(i);
		end
		for (int i = 1; i < 5; i++) begin
			w.sum5[i - 1] = 11'(a0) * 11'(5 - i) + 11'(a1) * 11'(i);
		end
		w.seven_step = a0 > a1;
		w.cidx = blk.color_half[63:32];
		w.aidx = blk.alpha_half[63:16];
	end

endmodule

@@ rtl/core/dxtd_palette.sv @@
// divides the weighted sums into the four-colour palette and eight-entry alpha ramp
module dxtd_palette (
	input  dxtd_pkg::wsum_t    w,
	output dxtd_pkg::palette_t p
);
	import dxtd_pkg::*;

	always_comb begin
		p = '0;
		for (int k = 0; k < 3; k++) begin
			p.pal[0][k] = w.e0[k];
			p.pal[1][k] = w.e1[k];
			if (w.four_color) begin
				p.pal[2][k] = div3(w.sum_a[k]);
				p.pal[3][k] = div3(w.sum_b[k]);
			end else begin
				p.pal[2][k] = w.sum_m[k][8:1];
				p.pal[3][k] = 8'h00;
			end
		end
		p.ramp[0] = w.a0;
		p.ramp[1] = w.a1;
		for (int i = 1; i < 5; i++) begin
			p.ramp[i + 1] = w.seven_step ? div7(w.sum7[i - 1]) : div5(w.sum5[i - 1]);
		end
		p.ramp[6] = w.seven_step ? div7(w.sum7[4]) : 8'h00;
		p.ramp[7] = w.seven_step ? div7(w.sum7[5]) : 8'hFF;
		p.cidx = w.cidx;
		p.aidx = w.aidx;
	end

endmodule

@@ rtl/core/dxt_texture_block_decoder_core.sv @@
// texture block decoder top level: block request in, sixteen rgba texels out
//
//  channel   | handshake           | payload
//  ----------+---------------------+----------------------------
//  block     | start / busy        | blk (color_half, alpha_half)
//  texel     | texel_stb           | texel (index, rgba, last)
//  config    | cfg_wr_en           | cfg_wr_data (format_dxt5)
//
// each block gives sixteen texels, one texel per cycle from the emit stage counter;
// blocks follow each other with no gap between their texels.
// a block passes the input register, then the weights, palette and emit stages, before its first texel shows.
// busy rises while a third block waits behind two in flight.
// reset clears the valid flags, the counter, the strobe and format_dxt5.
// the texel channel cannot stall; each texel is shown for one cycle.
module dxt_texture_block_decoder_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  dxtd_pkg::block_t  blk,
	input  logic              cfg_wr_en,
	input  logic              cfg_wr_data,
	output logic              texel_stb,
	output dxtd_pkg::texel_t  texel
);
	import dxtd_pkg::*;

	logic       fmt_q;
	block_t     blk_s1;
	logic       valid_s1;
	wsum_t      w_comb;
	wsum_t      w_s2;
	logic       valid_s2;
	palette_t   pal_comb;
	palette_t   pal_s3;
	logic       valid_s3;
	logic [3:0] cnt_s3;
	texel_t     texel_q;
	logic       stb_q;

	logic       accept;
	logic       last_s3;
	logic       load_s2;
	logic       load_s3;
	logic [4:0] cbit;
	logic [5:0] abit;
	logic [1:0] csel;
	logic [2:0] asel;

	dxtd_weights u_weights (
		.blk (blk_s1),
		.w   (w_comb)
	);

	dxtd_palette u_palette (
		.w (w_s2),
		.p (pal_comb)
	);

	assign last_s3 = cnt_s3 == 4'(Texels - 1);
	assign load_s3 = valid_s2 && (!valid_s3 || last_s3);
	assign load_s2 = valid_s1 && (!valid_s2 || load_s3);
	assign busy    = valid_s1 && !load_s2;
	assign accept  = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= 1'b0;
		end else if (cfg_wr_en) begin
			fmt_q <= cfg_wr_data;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			cnt_s3   <= '0;
			stb_q    <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (load_s2) begin
				valid_s1 <= 1'b0;
			end
			if (load_s2) begin
				valid_s2 <= 1'b1;
			end else if (load_s3) begin
				valid_s2 <= 1'b0;
			end
			if (load_s3) begin
				valid_s3 <= 1'b1;
				cnt_s3   <= '0;
			end else if (valid_s3) begin
				if (last_s3) begin
					valid_s3 <= 1'b0;
				end
				cnt_s3 <= cnt_s3 + 4'd1;
			end
			stb_q <= valid_s3;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			blk_s1 <= blk;
		end
		if (load_s2) begin
			w_s2 <= w_comb;
		end
		if (load_s3) begin
			pal_s3 <= pal_comb;
		end
		if (valid_s3) begin
			texel_q.texel_index <= cnt_s3;
			texel_q.red         <= pal_s3.pal[csel][0];
			texel_q.green       <= pal_s3.pal[csel][1];
			texel_q.blue        <= pal_s3.pal[csel][2];
			texel_q.alpha       <= fmt_q ? pal_s3.ramp[asel] : 8'hFF;
			texel_q.last_texel  <= last_s3;
		end
	end

	assign cbit = {cnt_s3, 1'b0};
	assign abit = {1'b0, cnt_s3, 1'b0} + 6'(cnt_s3);
	assign csel = pal_s3.cidx[cbit +: 2];
	assign asel = pal_s3.aidx[abit +: 3];

	assign texel_stb = stb_q;
	assign texel     = texel_q;

endmodule

@@ rtl/core/dxtd_checker.sv @@
// port-level checks on the texel stream of the decoder, bound to the top level
`include "dxt_texture_block_decoder_core_macros.svh"

module dxtd_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             texel_stb,
	input dxtd_pkg::texel_t texel
);
	import dxtd_pkg::*;

	`DXTD_ASSERT_ALWAYS(a_no_stb_after_reset, !arst_n |=> !texel_stb, "texel strobe right after reset")
	`DXTD_ASSERT(a_index_steps, texel_stb && !texel.last_texel |=> texel_stb && (texel.texel_index == 4'($past(texel.texel_index) + 4'd1)), "texel stream broke inside a block")
	`DXTD_ASSERT(a_last_marks_end, texel_stb |-> (texel.last_texel == (texel.texel_index == 4'(Texels - 1))), "last texel flag out of place")
	`DXTD_ASSERT(a_block_opens_at_zero, texel_stb && !($past(texel_stb) && !$past(texel.last_texel)) |-> texel.texel_index == 4'd0, "block does not open at texel zero")

endmodule

bind dxt_texture_block_decoder_core dxtd_checker u_dxtd_checker (.*);
